// ===== hdl/drd_pkg.sv =====
// Shared types and constants for the detection row decoder.
// Depends on nothing; imported by the front, back and top-level modules.
package drd_pkg;

    localparam int BOX_FIELDS  = 5;
    localparam int CLASS_BITS  = 7;
    localparam int THRESH_BITS = 13;
    localparam int SCALE_BITS  = 16;
    localparam int PIXEL_BITS  = 16;
    localparam int INDEX_BITS  = 3;
    localparam int DATA_BITS   = 16;
    localparam int BOX_FRAC    = 25;

    localparam int POS_CX  = 0;
    localparam int POS_CY  = 1;
    localparam int POS_W   = 2;
    localparam int POS_H   = 3;
    localparam int POS_OBJ = 4;

    typedef enum logic [INDEX_BITS-1:0] {
        REG_CONFIDENCE = 3'd0,
        REG_SCORE      = 3'd1,
        REG_X_SCALE    = 3'd2,
        REG_Y_SCALE    = 3'd3,
        REG_CLASSES    = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [THRESH_BITS-1:0] conf_level;
        logic [THRESH_BITS-1:0] score_level;
        logic [SCALE_BITS-1:0]  x_scale;
        logic [SCALE_BITS-1:0]  y_scale;
        logic [CLASS_BITS-1:0]  num_classes;
    } cfg_t;

endpackage

// ===== hdl/drd_queue.sv =====
// Small register-based FIFO used between decoder stages and at the result side.
// Depends on nothing; DEPTH must be a power of two.
module drd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign full     = (count_reg == CNT_BITS'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/drd_front.sv =====
// Front end of the detection row decoder: tracks row position, latches box
// fields, keeps the running best class and tests thresholds. Uses drd_pkg.
module drd_front #(
    parameter int MAX_CLASSES = 80,
    parameter int VALUE_BITS  = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic signed [VALUE_BITS-1:0]   value,
    input  drd_pkg::cfg_t                  cfg,
    output logic                           rec_push,
    output logic [drd_pkg::CLASS_BITS-1:0] rec_class,
    output logic signed [VALUE_BITS-1:0]   rec_obj,
    output logic signed [VALUE_BITS+1:0]   rec_dx,
    output logic signed [VALUE_BITS+1:0]   rec_dy,
    output logic signed [VALUE_BITS-1:0]   rec_w,
    output logic signed [VALUE_BITS-1:0]   rec_h
);
    import drd_pkg::*;

    localparam int POS_BITS = $clog2(MAX_CLASSES + BOX_FIELDS);
    localparam int VB       = VALUE_BITS;

    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic signed [VB-1:0]  cx_reg, cx_next;
    logic signed [VB-1:0]  cy_reg, cy_next;
    logic signed [VB-1:0]  w_reg, w_next;
    logic signed [VB-1:0]  h_reg, h_next;
    logic signed [VB-1:0]  obj_reg, obj_next;
    logic signed [VB+1:0]  dx_reg, dx_next;
    logic signed [VB+1:0]  dy_reg, dy_next;
    logic signed [VB-1:0]  best_reg, best_next;
    logic [CLASS_BITS-1:0] class_reg, class_next;

    logic [CLASS_BITS-1:0] count;
    logic [POS_BITS-1:0]   last_pos;
    logic                  take_score;
    logic signed [VB-1:0]  best_cand;
    logic [CLASS_BITS-1:0] class_cand;
    logic                  row_end;
    logic                  pass;

    always_comb
    begin
        if (cfg.num_classes == '0)
        begin
            count = CLASS_BITS'(1);
        end
        else if (cfg.num_classes > CLASS_BITS'(MAX_CLASSES))
        begin
            count = CLASS_BITS'(MAX_CLASSES);
        end
        else
        begin
            count = cfg.num_classes;
        end
    end

    assign last_pos   = POS_BITS'(BOX_FIELDS - 1) + POS_BITS'(count);
    assign take_score = (pos_reg == POS_BITS'(BOX_FIELDS)) || (value > best_reg);
    assign best_cand  = take_score ? value : best_reg;
    assign class_cand = take_score ? CLASS_BITS'(pos_reg - POS_BITS'(BOX_FIELDS))
                                   : class_reg;
    assign row_end    = (pos_reg >= POS_BITS'(BOX_FIELDS)) && (pos_reg >= last_pos);
    assign pass       = (obj_reg >= VB'($signed({1'b0, cfg.conf_level})))
                     && (best_cand > VB'($signed({1'b0, cfg.score_level})));

    assign rec_push  = accept && row_end && pass;
    assign rec_class = class_cand;
    assign rec_obj   = obj_reg;
    assign rec_dx    = dx_reg;
    assign rec_dy    = dy_reg;
    assign rec_w     = w_reg;
    assign rec_h     = h_reg;

    always_comb
    begin
        pos_next   = pos_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        w_next     = w_reg;
        h_next     = h_reg;
        obj_next   = obj_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        best_next  = best_reg;
        class_next = class_reg;
        if (accept)
        begin
            case (pos_reg)
                POS_BITS'(POS_CX):  cx_next = value;
                POS_BITS'(POS_CY):  cy_next = value;
                POS_BITS'(POS_W):
                begin
                    w_next  = value;
                    dx_next = {cx_reg[VB-1], cx_reg, 1'b0} - {{2{value[VB-1]}}, value};
                end
                POS_BITS'(POS_H):
                begin
                    h_next  = value;
                    dy_next = {cy_reg[VB-1], cy_reg, 1'b0} - {{2{value[VB-1]}}, value};
                end
                POS_BITS'(POS_OBJ): obj_next = value;
                default:
                begin
                    best_next  = best_cand;
                    class_next = class_cand;
                end
            endcase
            if (row_end)
            begin
                pos_next   = '0;
                best_next  = '0;
                class_next = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            w_reg     <= '0;
            h_reg     <= '0;
            obj_reg   <= '0;
            dx_reg    <= '0;
            dy_reg    <= '0;
            best_reg  <= '0;
            class_reg <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            w_reg     <= w_next;
            h_reg     <= h_next;
            obj_reg   <= obj_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            best_reg  <= best_next;
            class_reg <= class_next;
        end
    end

endmodule

// ===== hdl/drd_back.sv =====
// Back end of the detection row decoder: scales the box to image pixels,
// truncates toward zero and saturates. Uses drd_pkg.
module drd_back #(
    parameter int VALUE_BITS = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  drd_pkg::cfg_t                  cfg,
    input  logic                           in_empty,
    output logic                           in_pop,
    input  logic [drd_pkg::CLASS_BITS-1:0] in_class,
    input  logic signed [VALUE_BITS-1:0]   in_obj,
    input  logic signed [VALUE_BITS+1:0]   in_dx,
    input  logic signed [VALUE_BITS+1:0]   in_dy,
    input  logic signed [VALUE_BITS-1:0]   in_w,
    input  logic signed [VALUE_BITS-1:0]   in_h,
    input  logic                           out_full,
    output logic                           out_push,
    output logic [drd_pkg::CLASS_BITS-1:0] out_class,
    output logic signed [VALUE_BITS-1:0]   out_obj,
    output logic signed [drd_pkg::PIXEL_BITS-1:0] out_left,
    output logic signed [drd_pkg::PIXEL_BITS-1:0] out_top,
    output logic signed [drd_pkg::PIXEL_BITS-1:0] out_width,
    output logic signed [drd_pkg::PIXEL_BITS-1:0] out_height
);
    import drd_pkg::*;

    localparam int VB  = VALUE_BITS;
    localparam int OPW = VB + 2;
    localparam int PW  = OPW + SCALE_BITS + 1;

    logic                  s1_valid_reg, s1_valid_next;
    logic [CLASS_BITS-1:0] s1_class_reg;
    logic signed [VB-1:0]  s1_obj_reg;
    logic signed [PW-1:0]  s1_px_reg, s1_py_reg, s1_pw_reg, s1_ph_reg;

    logic signed [OPW-1:0] w2, h2;
    logic signed [SCALE_BITS:0] xs, ys;

    function automatic logic [PIXEL_BITS-1:0] trunc_sat(input logic signed [PW-1:0] x);
        logic [PW-1:0] mag;
        logic [PW-1:0] sh;
        logic [PW-1:0] neg_sh;
        mag    = x[PW-1] ? ('0 - x) : x;
        sh     = mag >> BOX_FRAC;
        neg_sh = '0 - sh;
        if (x[PW-1])
        begin
            trunc_sat = (sh > PW'(32768)) ? PIXEL_BITS'(16'h8000) : neg_sh[PIXEL_BITS-1:0];
        end
        else
        begin
            trunc_sat = (sh > PW'(32767)) ? PIXEL_BITS'(16'h7fff) : sh[PIXEL_BITS-1:0];
        end
    endfunction

    assign w2 = {in_w[VB-1], in_w, 1'b0};
    assign h2 = {in_h[VB-1], in_h, 1'b0};
    assign xs = $signed({1'b0, cfg.x_scale});
    assign ys = $signed({1'b0, cfg.y_scale});

    assign out_push      = s1_valid_reg && !out_full;
    assign in_pop        = !in_empty && (!s1_valid_reg || !out_full);
    assign s1_valid_next = in_pop ? 1'b1 : (out_push ? 1'b0 : s1_valid_reg);

    assign out_class  = s1_class_reg;
    assign out_obj    = s1_obj_reg;
    assign out_left   = trunc_sat(s1_px_reg);
    assign out_top    = trunc_sat(s1_py_reg);
    assign out_width  = trunc_sat(s1_pw_reg);
    assign out_height = trunc_sat(s1_ph_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_pop)
        begin
            s1_class_reg <= in_class;
            s1_obj_reg   <= in_obj;
            s1_px_reg    <= PW'(in_dx) * PW'(xs);
            s1_py_reg    <= PW'(in_dy) * PW'(ys);
            s1_pw_reg    <= PW'(w2) * PW'(xs);
            s1_ph_reg    <= PW'(h2) * PW'(ys);
        end
    end

endmodule

// ===== hdl/detection_row_decoder.sv =====
// Top level of the detection row decoder: configuration registers, front end,
// hand-off queue, scaling back end and result queue. Uses drd_pkg and submodules.
//
// Usage:
//   Row values enter one per transaction on value (push / full): cx, cy, w, h,
//   objectness, then num_classes class scores (zero reads as one, more than
//   MAX_CLASSES as MAX_CLASSES). A row that passes both thresholds yields one
//   detection transaction on the result side (empty / pop); the oldest
//   detection stays on the result ports while empty is low. A failing row
//   yields nothing. Throughput: one value per cycle while full is low.
//   Path: a detection enters the hand-off queue at the edge that takes the last
//   value of its row, is then registered in the multiply stage and then written
//   into the result queue, from which it can be popped.
//   When pop is held low, results collect in a two-entry result queue, then
//   the multiply stage and the two-entry hand-off queue fill; full rises only
//   when the hand-off queue is full, so several rows may be in flight.
//   Configuration: write_enable, register_index, write_data; write only while
//   idle. Indexes 0..4: confidence threshold, score threshold, x scale,
//   y scale, class count. Other indexes are ignored.
//   Reset: all queues empty, row position zero, registers at their defaults.
module detection_row_decoder #(
    parameter int MAX_CLASSES = 80,
    parameter int VALUE_BITS  = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic signed [VALUE_BITS-1:0]          value,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [drd_pkg::CLASS_BITS-1:0]        class_id,
    output logic signed [VALUE_BITS-1:0]          confidence,
    output logic signed [drd_pkg::PIXEL_BITS-1:0] box_left,
    output logic signed [drd_pkg::PIXEL_BITS-1:0] box_top,
    output logic signed [drd_pkg::PIXEL_BITS-1:0] box_width,
    output logic signed [drd_pkg::PIXEL_BITS-1:0] box_height,
    input  logic                                  write_enable,
    input  logic [drd_pkg::INDEX_BITS-1:0]        register_index,
    input  logic [drd_pkg::DATA_BITS-1:0]         write_data
);
    import drd_pkg::*;

    localparam int VB        = VALUE_BITS;
    localparam int MID_WIDTH = CLASS_BITS + VB + 2 * (VB + 2) + 2 * VB;
    localparam int OUT_WIDTH = CLASS_BITS + VB + 4 * PIXEL_BITS;

    cfg_t cfg_reg, cfg_next;

    logic                  accept;
    logic                  rec_push;
    logic [CLASS_BITS-1:0] rec_class;
    logic signed [VB-1:0]  rec_obj, rec_w, rec_h;
    logic signed [VB+1:0]  rec_dx, rec_dy;

    logic [MID_WIDTH-1:0]  mid_push_data, mid_pop_data;
    logic                  mid_full, mid_empty, mid_pop;
    logic [CLASS_BITS-1:0] mid_class;
    logic signed [VB-1:0]  mid_obj, mid_w, mid_h;
    logic signed [VB+1:0]  mid_dx, mid_dy;

    logic                          res_full, res_push;
    logic [CLASS_BITS-1:0]         res_class;
    logic signed [VB-1:0]          res_obj;
    logic signed [PIXEL_BITS-1:0]  res_left, res_top, res_width, res_height;
    logic [OUT_WIDTH-1:0]          res_push_data, res_pop_data;

    assign accept = push && !full;
    assign full   = mid_full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_enable)
        begin
            unique case (register_index)
                REG_CONFIDENCE: cfg_next.conf_level  = write_data[THRESH_BITS-1:0];
                REG_SCORE:      cfg_next.score_level = write_data[THRESH_BITS-1:0];
                REG_X_SCALE:    cfg_next.x_scale     = write_data[SCALE_BITS-1:0];
                REG_Y_SCALE:    cfg_next.y_scale     = write_data[SCALE_BITS-1:0];
                REG_CLASSES:    cfg_next.num_classes = write_data[CLASS_BITS-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.conf_level  <= THRESH_BITS'(1843);
            cfg_reg.score_level <= THRESH_BITS'(2048);
            cfg_reg.x_scale     <= SCALE_BITS'(4096);
            cfg_reg.y_scale     <= SCALE_BITS'(4096);
            cfg_reg.num_classes <= CLASS_BITS'(80);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    drd_front #(
        .MAX_CLASSES (MAX_CLASSES),
        .VALUE_BITS  (VALUE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .value     (value),
        .cfg       (cfg_reg),
        .rec_push  (rec_push),
        .rec_class (rec_class),
        .rec_obj   (rec_obj),
        .rec_dx    (rec_dx),
        .rec_dy    (rec_dy),
        .rec_w     (rec_w),
        .rec_h     (rec_h)
    );

    assign mid_push_data = {rec_class, rec_obj, rec_dx, rec_dy, rec_w, rec_h};

    drd_queue #(
        .WIDTH (MID_WIDTH),
        .DEPTH (2)
    ) u_mid_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rec_push),
        .push_data (mid_push_data),
        .full      (mid_full),
        .pop       (mid_pop),
        .pop_data  (mid_pop_data),
        .empty     (mid_empty)
    );

    assign {mid_class, mid_obj, mid_dx, mid_dy, mid_w, mid_h} = mid_pop_data;

    drd_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_empty   (mid_empty),
        .in_pop     (mid_pop),
        .in_class   (mid_class),
        .in_obj     (mid_obj),
        .in_dx      (mid_dx),
        .in_dy      (mid_dy),
        .in_w       (mid_w),
        .in_h       (mid_h),
        .out_full   (res_full),
        .out_push   (res_push),
        .out_class  (res_class),
        .out_obj    (res_obj),
        .out_left   (res_left),
        .out_top    (res_top),
        .out_width  (res_width),
        .out_height (res_height)
    );

    assign res_push_data = {res_class, res_obj, res_left, res_top, res_width, res_height};

    drd_queue #(
        .WIDTH (OUT_WIDTH),
        .DEPTH (2)
    ) u_res_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_push_data),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (res_pop_data),
        .empty     (empty)
    );

    assign {class_id, confidence, box_left, box_top, box_width, box_height} = res_pop_data;

endmodule

// ===== test/tb_detection_row_decoder.sv =====
`timescale 1ns / 100ps
// Testbench for detection_row_decoder: streams detector rows through the value
// queue and compares every detection with a predictor kept in this file or with
// a fixed expected box. Depends on drd_pkg and the detection_row_decoder RTL.
module tb_detection_row_decoder;
    import drd_pkg::*;

    localparam int MAX_CLASSES  = 80;
    localparam int VALUE_BITS   = 24;
    localparam int LIMIT_CYCLES = 200000;
    localparam int SETTLE       = 8;
    localparam int HOLD_CYCLES  = 600;

    typedef struct packed {
        logic [CLASS_BITS-1:0]        class_id;
        logic signed [VALUE_BITS-1:0] confidence;
        logic signed [PIXEL_BITS-1:0] box_left;
        logic signed [PIXEL_BITS-1:0] box_top;
        logic signed [PIXEL_BITS-1:0] box_width;
        logic signed [PIXEL_BITS-1:0] box_height;
    } detection_t;

    typedef enum {FROM_MODEL, WANT_HIT, WANT_MISS} row_check_t;

    typedef struct {
        logic signed [VALUE_BITS-1:0] value;
        row_check_t                   check;
        detection_t                   want;
    } stim_row_t;

    typedef struct {
        int confidence;
        int score;
        int x_ratio;
        int y_ratio;
        int classes;
    } setting_t;

    localparam detection_t NO_DETECTION = '0;
    localparam detection_t PLAIN_BOX    = '{0, 4096, 90, 45, 20, 10};

    logic                                clk;
    logic                                rst_n;
    logic                                push;
    logic                                full;
    logic signed [VALUE_BITS-1:0]        value;
    logic                                empty;
    logic                                pop;
    logic [CLASS_BITS-1:0]               class_id;
    logic signed [VALUE_BITS-1:0]        confidence;
    logic signed [PIXEL_BITS-1:0]        box_left;
    logic signed [PIXEL_BITS-1:0]        box_top;
    logic signed [PIXEL_BITS-1:0]        box_width;
    logic signed [PIXEL_BITS-1:0]        box_height;
    logic                                write_enable;
    logic [INDEX_BITS-1:0]               register_index;
    logic [DATA_BITS-1:0]                write_data;

    detection_row_decoder #(
        .MAX_CLASSES(MAX_CLASSES),
        .VALUE_BITS (VALUE_BITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .value         (value),
        .empty         (empty),
        .pop           (pop),
        .class_id      (class_id),
        .confidence    (confidence),
        .box_left      (box_left),
        .box_top       (box_top),
        .box_width     (box_width),
        .box_height    (box_height),
        .write_enable  (write_enable),
        .register_index(register_index),
        .write_data    (write_data)
    );

    // Row decoder state and register copies
    int     row_pos;
    longint cx_q, cy_q, w_q, h_q, obj_q, top_score;
    int     top_class;
    int     conf_limit, score_limit, x_ratio, y_ratio, class_setting;

    detection_t pending_detections[$];
    int         mismatches;
    int         values_taken;
    int         detections_checked;
    int         settings_applied;
    int         cycles;
    int         sender_idle_pct;
    int         receiver_idle_pct;

    stim_row_t directed_rows[28] = '{
        '{24'h064000, FROM_MODEL, NO_DETECTION},
        '{24'h032000, FROM_MODEL, NO_DETECTION},
        '{24'h014000, FROM_MODEL, NO_DETECTION},
        '{24'h00A000, FROM_MODEL, NO_DETECTION},
        '{24'h001000, FROM_MODEL, NO_DETECTION},
        '{24'h000BB8, FROM_MODEL, NO_DETECTION},
        '{24'h000BB8, WANT_HIT,   PLAIN_BOX},
        '{24'h800000, FROM_MODEL, NO_DETECTION},
        '{24'h7FFFFF, FROM_MODEL, NO_DETECTION},
        '{24'h7FFFFF, FROM_MODEL, NO_DETECTION},
        '{24'h800000, FROM_MODEL, NO_DETECTION},
        '{24'h7FFFFF, FROM_MODEL, NO_DETECTION},
        '{24'h800000, FROM_MODEL, NO_DETECTION},
        '{24'h7FFFFF, FROM_MODEL, NO_DETECTION},
        '{24'h000000, FROM_MODEL, NO_DETECTION},
        '{24'h000000, FROM_MODEL, NO_DETECTION},
        '{24'h000000, FROM_MODEL, NO_DETECTION},
        '{24'h000000, FROM_MODEL, NO_DETECTION},
        '{24'h000732, FROM_MODEL, NO_DETECTION},
        '{24'h000801, FROM_MODEL, NO_DETECTION},
        '{24'h001388, WANT_MISS,  NO_DETECTION},
        '{24'h000000, FROM_MODEL, NO_DETECTION},
        '{24'h000000, FROM_MODEL, NO_DETECTION},
        '{24'h000000, FROM_MODEL, NO_DETECTION},
        '{24'h000000, FROM_MODEL, NO_DETECTION},
        '{24'h000733, FROM_MODEL, NO_DETECTION},
        '{24'h000800, FROM_MODEL, NO_DETECTION},
        '{24'hFFFFFF, WANT_MISS,  NO_DETECTION}
    };

    setting_t settings[8] = '{
        '{1843, 2048,  4096,  4096,   2},
        '{   0,    0, 65535, 65535,   1},
        '{4096, 4096,     0,     0,   3},
        '{1843, 2048,  4096,  4096,  80},
        '{2000, 1000,  8192,  2048,   0},
        '{   1, 4095,  1234, 40000, 127},
        '{3000, 2500, 65535,     1,   5},
        '{ 500,  300, 20000, 30000,  12}
    };

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("Run stopped at the cycle limit");
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic signed [PIXEL_BITS-1:0] to_pixels(longint x, int frac);
        longint mag;
        if (x < 0)
        begin
            mag = (-x) >> frac;
            return (mag > 32768) ? -16'sd32768 : PIXEL_BITS'(-mag);
        end
        mag = x >> frac;
        return (mag > 32767) ? 16'sd32767 : PIXEL_BITS'(mag);
    endfunction

    task automatic decode_value(input logic signed [VALUE_BITS-1:0] v,
                                output bit hit, output detection_t det);
        longint s;
        int     count;
        int     last;
        s = v;
        count = (class_setting == 0) ? 1
              : (class_setting > MAX_CLASSES) ? MAX_CLASSES : class_setting;
        last = BOX_FIELDS - 1 + count;
        hit = 1'b0;
        det = NO_DETECTION;
        case (row_pos)
            POS_CX:  cx_q = s;
            POS_CY:  cy_q = s;
            POS_W:   w_q = s;
            POS_H:   h_q = s;
            POS_OBJ: obj_q = s;
            default:
            begin
                if (row_pos == BOX_FIELDS || s > top_score)
                begin
                    top_score = s;
                    top_class = (row_pos - BOX_FIELDS) & 'h7F;
                end
            end
        endcase
        if (row_pos < BOX_FIELDS || row_pos < last)
            row_pos++;
        else
        begin
            hit = (obj_q >= conf_limit) && (top_score > score_limit);
            if (hit)
            begin
                det.class_id   = CLASS_BITS'(top_class);
                det.confidence = obj_q[VALUE_BITS-1:0];
                det.box_left   = to_pixels((2 * cx_q - w_q) * x_ratio, BOX_FRAC);
                det.box_top    = to_pixels((2 * cy_q - h_q) * y_ratio, BOX_FRAC);
                det.box_width  = to_pixels(w_q * x_ratio, BOX_FRAC - 1);
                det.box_height = to_pixels(h_q * y_ratio, BOX_FRAC - 1);
            end
            row_pos = 0;
            top_score = 0;
            top_class = 0;
        end
    endtask

    // Mostly well-formed rows: boxes of moderate size, scores near the thresholds
    function automatic logic signed [VALUE_BITS-1:0] next_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return VALUE_BITS'($urandom);
        if (row_pos < POS_OBJ)
            return (r < 22) ? VALUE_BITS'($urandom)
                            : VALUE_BITS'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
        if (row_pos == POS_OBJ)
            return VALUE_BITS'(conf_limit + int'($urandom_range(0, 800)) - 300);
        if (r < 25 && row_pos > BOX_FIELDS)
            return VALUE_BITS'(top_score);
        return VALUE_BITS'(score_limit + int'($urandom_range(0, 1000)) - 400);
    endfunction

    task automatic check_field(string field, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    task automatic send_value(input logic signed [VALUE_BITS-1:0] v, input row_check_t check,
                              input detection_t want);
        bit         hit;
        detection_t det;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push  <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (full);
        values_taken++;
        decode_value(v, hit, det);
        if (check == WANT_HIT)
            pending_detections.insert(pending_detections.size(), want);
        else if (check == FROM_MODEL && hit)
            pending_detections.insert(pending_detections.size(), det);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (pending_detections.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input int data);
        write_enable   <= 1'b1;
        register_index <= idx;
        write_data     <= DATA_BITS'(data);
        @(posedge clk);
    endtask

    task automatic apply_setting(input setting_t s);
        wait_idle();
        write_reg(REG_CONFIDENCE, s.confidence);
        write_reg(REG_SCORE, s.score);
        write_reg(REG_X_SCALE, s.x_ratio);
        write_reg(REG_Y_SCALE, s.y_ratio);
        write_reg(REG_CLASSES, s.classes);
        write_enable <= 1'b0;
        conf_limit    = s.confidence & 'h1FFF;
        score_limit   = s.score & 'h1FFF;
        x_ratio       = s.x_ratio & 'hFFFF;
        y_ratio       = s.y_ratio & 'hFFFF;
        class_setting = s.classes & 'h7F;
        settings_applied++;
    endtask

    // Result side: check each transaction, then pick the next pop
    initial
    begin
        int         hold_left;
        bit         held;
        detection_t want;
        hold_left = 0;
        held = 1'b0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (pending_detections.size() == 0)
                begin
                    $error("detection with none expected: class_id %0d", class_id);
                    mismatches++;
                end
                else
                begin
                    want = pending_detections.pop_front();
                    detections_checked++;
                    check_field("class_id", want.class_id, class_id);
                    check_field("confidence", want.confidence, confidence);
                    check_field("box_left", want.box_left, box_left);
                    check_field("box_top", want.box_top, box_top);
                    check_field("box_width", want.box_width, box_width);
                    check_field("box_height", want.box_height, box_height);
                end
            end
            if (!held && values_taken >= 250)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    initial
    begin
        int random_sent;
        int phase_items;
        mismatches = 0;
        values_taken = 0;
        detections_checked = 0;
        settings_applied = 0;
        cycles = 0;
        random_sent = 0;
        sender_idle_pct = 26;
        receiver_idle_pct = 45;
        rst_n          <= 1'b0;
        push           <= 1'b0;
        value          <= '0;
        write_enable   <= 1'b0;
        register_index <= '0;
        write_data     <= '0;
        row_pos = 0;
        cx_q = 0;
        cy_q = 0;
        w_q = 0;
        h_q = 0;
        obj_q = 0;
        top_score = 0;
        top_class = 0;
        conf_limit = 1843;
        score_limit = 2048;
        x_ratio = 4096;
        y_ratio = 4096;
        class_setting = 80;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apply_setting(settings[0]);
        foreach (directed_rows[i])
            send_value(directed_rows[i].value, directed_rows[i].check, directed_rows[i].want);

        for (int p = 1; p < 8; p++)
        begin
            apply_setting(settings[p]);
            phase_items = $urandom_range(170, 260);
            repeat (phase_items)
            begin
                // swap the idle rates after 500 random values, drop them to zero after 1000
                if (random_sent == 500)
                begin
                    sender_idle_pct = 45;
                    receiver_idle_pct = 26;
                end
                else if (random_sent == 1000)
                begin
                    sender_idle_pct = 0;
                    receiver_idle_pct = 0;
                end
                send_value(next_value(), FROM_MODEL, NO_DETECTION);
                random_sent++;
            end
        end

        wait_idle();
        $display("Sent %0d row values under %0d register settings, checked %0d detections",
                 values_taken, settings_applied, detections_checked);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
